FILE: rtl/core/rrf_pkg.sv
package rrf_pkg;

	localparam int DEPTH_DEF = 256;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

endpackage

FILE: rtl/core/rrf_ctrl.sv
module rrf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output rrf_pkg::ctrl_cmd_t cmd
);
	import rrf_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = start ? S_EXEC : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy     = (state_q == S_EXEC);
		done     = (state_q == S_DONE);
		cmd.load = start && (state_q != S_EXEC);
		cmd.exec = (state_q == S_EXEC);
	end

endmodule

FILE: rtl/core/rrf_datapath.sv
module rrf_datapath #(
	parameter int DEPTH = rrf_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rrf_pkg::ctrl_cmd_t cmd,
	input  logic [1:0]         opcode,
	input  logic [7:0]         push_byte,
	output logic [7:0]         pop_byte,
	output logic               pop_valid,
	output logic [7:0]         fill_level,
	output logic               overwrote
);
	import rrf_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = (AW + 1 > 8) ? AW + 1 : 8;

	logic [7:0]    store_q [DEPTH];
	logic [1:0]    op_q;
	logic [7:0]    byte_q;
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW-1:0] wr_d;
	logic [AW-1:0] rd_d;
	logic [AW-1:0] wr_inc;
	logic [AW-1:0] rd_inc;
	logic          do_write;
	logic          do_read;
	logic          lost_d;
	logic          empty;
	logic [CW-1:0] fill_c;
	logic [7:0]    fill_d;
	logic [7:0]    rdata_q;
	logic          valid_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			byte_q <= push_byte;
		end
	end

	always_comb begin
		wr_inc = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
		rd_inc = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
		empty  = (wr_q == rd_q);
	end

	always_comb begin
		wr_d     = wr_q;
		rd_d     = rd_q;
		do_write = 1'b0;
		do_read  = 1'b0;
		lost_d   = 1'b0;
		case (op_t'(op_q))
			OP_PUSH: begin
				do_write = 1'b1;
				wr_d     = wr_inc;
				if (wr_inc == rd_q) begin
					rd_d   = rd_inc;
					lost_d = 1'b1;
				end
			end
			OP_POP: begin
				if (!empty) begin
					do_read = 1'b1;
					rd_d    = rd_inc;
				end
			end
			OP_CLEAR: begin
				wr_d = '0;
				rd_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (wr_d >= rd_d) begin
			fill_c = CW'(wr_d) - CW'(rd_d);
		end else begin
			fill_c = CW'(wr_d) + CW'(DEPTH) - CW'(rd_d);
		end
		fill_d = (fill_c > CW'(255)) ? 8'hFF : fill_c[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else if (cmd.exec) begin
			wr_q <= wr_d;
			rd_q <= rd_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && do_write) begin
			store_q[wr_q] <= byte_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && do_read) begin
			rdata_q <= store_q[rd_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			valid_q    <= do_read;
			overwrote  <= lost_d;
			fill_level <= fill_d;
		end
	end

	assign pop_valid = valid_q;
	assign pop_byte  = valid_q ? rdata_q : 8'h00;

endmodule

FILE: rtl/core/receive_ring_fifo_overwrite.sv
// An accepted item is latched with its opcode, executed in S_EXEC and strobed on done in S_DONE.
// Start is not taken while busy (S_EXEC); it is taken again in the done cycle.
// The byte store has a registered read and sees at most one access per item.
// The receiver cannot stall: done is high in the done cycle only; results hold until the next item executes.
// Reset (arst_n low) empties the ring; store contents are left undefined.
module receive_ring_fifo_overwrite #(
	parameter int DEPTH = rrf_pkg::DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] opcode,
	input  logic [7:0] push_byte,
	output logic       done,
	output logic [7:0] pop_byte,
	output logic       pop_valid,
	output logic [7:0] fill_level,
	output logic       overwrote
);
	import rrf_pkg::*;

	ctrl_cmd_t cmd;

	rrf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	rrf_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.opcode     (opcode),
		.push_byte  (push_byte),
		.pop_byte   (pop_byte),
		.pop_valid  (pop_valid),
		.fill_level (fill_level),
		.overwrote  (overwrote)
	);

endmodule

FILE: tb/ring_fifo_checker.sv
`timescale 1ns / 1ps

module ring_fifo_checker #(
	parameter int DEPTH = rrf_pkg::DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [1:0] opcode,
	input  logic [7:0] push_byte,
	input  logic       done,
	input  logic [7:0] pop_byte,
	input  logic       pop_valid,
	input  logic [7:0] fill_level,
	input  logic       overwrote,
	output int         fail_count,
	output int         pending,
	output int         results_seen,
	output int         overwrites_seen,
	output int         empty_pops_seen
);
	import rrf_pkg::*;

	typedef struct packed {
		logic [7:0] pop_byte;
		logic       pop_valid;
		logic [7:0] fill_level;
		logic       overwrote;
	} ring_result_t;

	ring_result_t expected_q[$];
	logic [7:0]   ring_mem [DEPTH];
	int unsigned  wr_ptr = 0;
	int unsigned  rd_ptr = 0;
	int           errors = 0;
	int           n_results = 0;
	int           n_overwrites = 0;
	int           n_empty_pops = 0;

	function automatic int unsigned ptr_next(int unsigned p);
		return (p + 1 >= DEPTH) ? 0 : p + 1;
	endfunction

	function automatic int unsigned bytes_held();
		return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + DEPTH - rd_ptr;
	endfunction

	// Applies one item to the ring model and returns the result it should produce.
	function automatic ring_result_t ring_apply(logic [1:0] op, logic [7:0] data);
		ring_result_t res;
		int unsigned  held;
		res = '0;
		case (op_t'(op))
			OP_PUSH: begin
				ring_mem[wr_ptr] = data;
				wr_ptr = ptr_next(wr_ptr);
				if (wr_ptr == rd_ptr) begin
					rd_ptr = ptr_next(rd_ptr);
					res.overwrote = 1'b1;
				end
			end
			OP_POP: begin
				if (bytes_held() != 0) begin
					res.pop_byte  = ring_mem[rd_ptr];
					res.pop_valid = 1'b1;
					rd_ptr = ptr_next(rd_ptr);
				end
			end
			OP_CLEAR: begin
				wr_ptr = 0;
				rd_ptr = 0;
			end
			default: ;
		endcase
		held = bytes_held();
		res.fill_level = (held > 255) ? 8'd255 : held[7:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ring_result_t exp_res;
		if (!arst_n) begin
			expected_q.delete();
			wr_ptr = 0;
			rd_ptr = 0;
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("result with no item outstanding: pop_byte %0d fill_level %0d",
						pop_byte, fill_level);
					errors++;
				end else begin
					exp_res = expected_q.pop_front();
					n_results++;
					if (pop_byte !== exp_res.pop_byte) begin
						$error("pop_byte: expected %0d, got %0d", exp_res.pop_byte, pop_byte);
						errors++;
					end
					if (pop_valid !== exp_res.pop_valid) begin
						$error("pop_valid: expected %0d, got %0d", exp_res.pop_valid, pop_valid);
						errors++;
					end
					if (fill_level !== exp_res.fill_level) begin
						$error("fill_level: expected %0d, got %0d", exp_res.fill_level,
							fill_level);
						errors++;
					end
					if (overwrote !== exp_res.overwrote) begin
						$error("overwrote: expected %0d, got %0d", exp_res.overwrote, overwrote);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				if (opcode == OP_POP && bytes_held() == 0)
					n_empty_pops++;
				exp_res = ring_apply(opcode, push_byte);
				if (exp_res.overwrote)
					n_overwrites++;
				expected_q.push_back(exp_res);
			end
		end
		fail_count      <= errors;
		pending         <= expected_q.size();
		results_seen    <= n_results;
		overwrites_seen <= n_overwrites;
		empty_pops_seen <= n_empty_pops;
	end

endmodule

FILE: tb/receive_ring_fifo_overwrite_tb.sv
`timescale 1ns / 1ps

module receive_ring_fifo_overwrite_tb;
	import rrf_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         STALL_LIMIT = 500;
	localparam int         BLOCK_ITEMS = 300;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [1:0] opcode = OP_PUSH;
	logic [7:0] push_byte = 8'd0;
	logic       done;
	logic [7:0] pop_byte;
	logic       pop_valid;
	logic [7:0] fill_level;
	logic       overwrote;

	int fail_count;
	int pending;
	int results_seen;
	int overwrites_seen;
	int empty_pops_seen;
	int items_sent = 0;
	int quiet_cycles = 0;
	bit gaps_on = 1'b1;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	receive_ring_fifo_overwrite i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.push_byte  (push_byte),
		.done       (done),
		.pop_byte   (pop_byte),
		.pop_valid  (pop_valid),
		.fill_level (fill_level),
		.overwrote  (overwrote)
	);

	ring_fifo_checker #(
		.DEPTH (DEPTH_DEF)
	) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.opcode          (opcode),
		.push_byte       (push_byte),
		.done            (done),
		.pop_byte        (pop_byte),
		.pop_valid       (pop_valid),
		.fill_level      (fill_level),
		.overwrote       (overwrote),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_seen    (results_seen),
		.overwrites_seen (overwrites_seen),
		.empty_pops_seen (empty_pops_seen)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("receive_ring_fifo_overwrite test failed");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [7:0] data);
		if (gaps_on && $urandom_range(99) < 22) begin
			start <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		start     <= 1'b1;
		opcode    <= op;
		push_byte <= data;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
	endtask

	initial begin
		int         push_pct [6];
		int         r;
		int         settle;
		logic [1:0] op;

		push_pct = '{95, 50, 12, 60, 90, 30};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_POP, 8'hFF);
		send_item(OP_PUSH, 8'h00);
		send_item(OP_PUSH, 8'hFF);
		send_item(OP_PUSH, 8'hA5);
		send_item(OP_PUSH, 8'h5A);
		send_item(OP_UNUSED, 8'hFF);
		send_item(OP_POP, 8'h00);
		send_item(OP_POP, 8'h00);
		send_item(OP_POP, 8'hFF);
		send_item(OP_POP, 8'h00);
		send_item(OP_POP, 8'h00);
		send_item(OP_UNUSED, 8'h00);
		send_item(OP_PUSH, 8'h81);
		send_item(OP_PUSH, 8'h7E);
		send_item(OP_CLEAR, 8'hFF);
		send_item(OP_POP, 8'h00);
		send_item(OP_PUSH, 8'h3C);
		send_item(OP_POP, 8'h00);
		send_item(OP_CLEAR, 8'h00);
		send_item(OP_CLEAR, 8'h00);

		// push-heavy blocks fill the ring and force overwrites, pop-heavy ones drain it
		for (int blk = 0; blk < 6; blk++) begin
			gaps_on = (blk != 3);
			for (int k = 0; k < BLOCK_ITEMS; k++) begin
				r = $urandom_range(199);
				if (r == 0)
					op = OP_CLEAR;
				else if (r == 1)
					op = OP_UNUSED;
				else
					op = ($urandom_range(99) < push_pct[blk]) ? OP_PUSH : OP_POP;
				send_item(op, 8'($urandom_range(255)));
			end
		end
		start <= 1'b0;

		settle = 0;
		while (pending != 0 && settle < 100) begin
			@(posedge clk);
			settle++;
		end
		repeat (8) @(posedge clk);

		$display("%0d items sent, %0d results checked, %0d overwrites, %0d empty pops",
			items_sent, results_seen, overwrites_seen, empty_pops_seen);
		if (fail_count == 0 && pending == 0)
			$display("receive_ring_fifo_overwrite test passed");
		else
			$display("receive_ring_fifo_overwrite test failed");
		$finish;
	end

endmodule
